>>> sv/lpg_pkg.sv
`timescale 1ns / 1ps

package lpg_pkg;

    localparam int VAL_W      = 4;
    localparam int SIZE_W     = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [SIZE_W-1:0] t_size;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_FILL,
        ST_EMIT,
        ST_EXH
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

>>> sv/lpg_mem.sv
`timescale 1ns / 1ps

module lpg_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic              i_clk,
    input  lpg_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_wr_addr,
    input  lpg_pkg::t_val     i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output lpg_pkg::t_val     o_rd_data
);
    import lpg_pkg::*;

    t_val r_mem [DEPTH];
    t_val r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/lpg_ctrl.sv
`timescale 1ns / 1ps

module lpg_ctrl #(
    parameter int MAX_SET = 8,
    parameter int AW      = 3,
    parameter int CW      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CW-1:0]     i_size,
    input  logic              i_cfg_clear,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_restart,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lpg_pkg::t_val     o_element,
    output logic              o_last_of_run,
    output logic              o_exhausted,
    output lpg_pkg::t_mem_ctl o_mem_ctl,
    output logic [AW-1:0]     o_wr_addr,
    output lpg_pkg::t_val     o_wr_data,
    output logic [AW-1:0]     o_rd_addr,
    input  lpg_pkg::t_val     i_rd_data
);
    import lpg_pkg::*;

    t_state             r_state, n_state;
    logic [MAX_SET-1:0] r_mask, n_mask;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_started, n_started;
    logic               r_done, n_done;
    logic               r_out_valid, n_out_valid;
    t_val               r_element, n_element;
    logic               r_last, n_last;
    logic               r_exh, n_exh;

    logic               accept;
    logic               out_free;
    logic [CW-1:0]      size_m1;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      cnt_p1;
    logic [MAX_SET-1:0] mask_rm;
    logic [MAX_SET-1:0] cand;
    logic               found;
    logic [AW-1:0]      cand_idx;
    logic [AW-1:0]      free_idx;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign size_m1  = i_size - 1'b1;
    assign cnt_m1   = r_cnt - 1'b1;
    assign cnt_p1   = r_cnt + 1'b1;

    // next larger unused value at the current level, and lowest free value for filling
    always_comb begin
        found    = 1'b0;
        cand_idx = '0;
        free_idx = '0;
        for (int i = 0; i < MAX_SET; i++) begin
            mask_rm[i] = r_mask[i] && (i_rd_data != VAL_W'(i + 1));
            cand[i]    = !mask_rm[i] && (VAL_W'(i + 1) > i_rd_data)
                         && (CW'(i + 1) <= i_size);
        end
        for (int i = MAX_SET - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found    = 1'b1;
                cand_idx = AW'(i);
            end
            if (!r_mask[i]) begin
                free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_cnt       = r_cnt;
        n_started   = r_started;
        n_done      = r_done;
        n_out_valid = r_out_valid && i_out_stall;
        n_element   = r_element;
        n_last      = r_last;
        n_exh       = r_exh;
        o_mem_ctl   = '0;
        o_wr_addr   = r_cnt[AW-1:0];
        o_wr_data   = '0;
        o_rd_addr   = r_cnt[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_restart || !r_started) begin
                        n_mask    = '0;
                        n_cnt     = '0;
                        n_started = 1'b1;
                        n_done    = 1'b0;
                        n_state   = ST_FILL;
                    end else if (r_done) begin
                        n_state = ST_EXH;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = size_m1[AW-1:0];
                        n_cnt           = size_m1;
                        n_state         = ST_BACK;
                    end
                end
            end
            ST_BACK: begin
                o_mem_ctl.wr_en = 1'b1;
                if (found) begin
                    o_wr_data = VAL_W'(cand_idx) + 1'b1;
                    n_mask    = mask_rm | (MAX_SET'(1) << cand_idx);
                    n_cnt     = cnt_p1;
                    n_state   = ST_FILL;
                end else begin
                    n_mask = mask_rm;
                    if (r_cnt == '0) begin
                        n_done  = 1'b1;
                        n_state = ST_EXH;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = cnt_m1[AW-1:0];
                        n_cnt           = cnt_m1;
                    end
                end
            end
            ST_FILL: begin
                if (r_cnt == i_size) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = '0;
                    n_cnt           = '0;
                    n_state         = ST_EMIT;
                end else begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_wr_data       = VAL_W'(free_idx) + 1'b1;
                    n_mask          = r_mask | (MAX_SET'(1) << free_idx);
                    n_cnt           = cnt_p1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_element   = i_rd_data;
                    n_last      = (r_cnt == size_m1);
                    n_exh       = 1'b0;
                    if (r_cnt == size_m1) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = cnt_p1[AW-1:0];
                        n_cnt           = cnt_p1;
                    end
                end
            end
            ST_EXH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_element   = '0;
                    n_last      = 1'b1;
                    n_exh       = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_clear) begin
            n_started = 1'b0;
            n_done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mask      <= '0;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= n_mask;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_element <= n_element;
        r_last    <= n_last;
        r_exh     <= n_exh;
    end

    assign o_in_stall    = (r_state != ST_IDLE) || !i_rst_n;
    assign o_out_valid   = r_out_valid;
    assign o_element     = r_element;
    assign o_last_of_run = r_last;
    assign o_exhausted   = r_exh;

endmodule

>>> sv/lexicographic_permutation_generator.sv
`timescale 1ns / 1ps

// channel   handshake                  payload
// in        i_in_valid / o_in_stall    i_restart
// out       o_out_valid / i_out_stall  o_element, o_last_of_run, o_exhausted
// cfg       i_cfg_valid / o_cfg_ready  i_cfg_set_size
//
// one item in flight; restart fills all positions lowest value first, then emits;
// advance scans back from the last position, one read per level, to a larger unused
// value, writes it, refills the rest, emits; past the end it emits an exhausted item
// synchronous active-low reset clears control state and sets the size to 4
// an output stall holds the emit sequence; input is stalled in reset and until the
// last item is loaded
module lexicographic_permutation_generator #(
    parameter int MAX_SET = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  lpg_pkg::t_size i_cfg_set_size,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_restart,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lpg_pkg::t_val o_element,
    output logic          o_last_of_run,
    output logic          o_exhausted
);
    import lpg_pkg::*;

    localparam int AW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
    localparam int CW = $clog2(MAX_SET + 1);

    t_size         r_set_size;
    logic          cfg_wr;
    t_size         size_clamped;
    logic [CW-1:0] size_eff;
    t_mem_ctl      mem_ctl;
    logic [AW-1:0] wr_addr;
    t_val          wr_data;
    logic [AW-1:0] rd_addr;
    t_val          rd_data;

    assign o_cfg_ready = i_rst_n;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size <= SIZE_RESET;
        end else if (cfg_wr) begin
            r_set_size <= i_cfg_set_size;
        end
    end

    // clamp to 1..MAX_SET
    always_comb begin
        priority if (r_set_size == '0) begin
            size_clamped = SIZE_W'(1);
        end else if (r_set_size > SIZE_W'(MAX_SET)) begin
            size_clamped = SIZE_W'(MAX_SET);
        end else begin
            size_clamped = r_set_size;
        end
    end

    assign size_eff = size_clamped[CW-1:0];

    lpg_ctrl #(
        .MAX_SET (MAX_SET),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_size        (size_eff),
        .i_cfg_clear   (cfg_wr),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_element     (o_element),
        .o_last_of_run (o_last_of_run),
        .o_exhausted   (o_exhausted),
        .o_mem_ctl     (mem_ctl),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    lpg_mem #(
        .DEPTH (MAX_SET),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

>>> tb/sv/lexicographic_permutation_generator_tb.sv
`timescale 1ns / 1ps

module lexicographic_permutation_generator_tb;
    import lpg_pkg::*;

    localparam int MAX_SET       = 8;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_REPORTS   = 10;
    localparam int EXP_DEPTH     = 64;

    typedef struct packed {
        t_val element;
        logic last_of_run;
        logic exhausted;
    } t_elem_result;

    logic  i_clk          = 1'b0;
    logic  i_rst_n        = 1'b0;
    logic  i_cfg_valid    = 1'b0;
    t_size i_cfg_set_size = '0;
    logic  i_in_valid     = 1'b0;
    logic  i_restart      = 1'b0;
    logic  i_out_stall    = 1'b0;
    logic  o_cfg_ready;
    logic  o_in_stall;
    logic  o_out_valid;
    t_val  o_element;
    logic  o_last_of_run;
    logic  o_exhausted;

    t_size              size_reg     = SIZE_RESET;
    t_val               chosen [MAX_SET];
    logic [MAX_SET-1:0] used_vals    = '0;
    bit                 perm_started = 1'b0;
    bit                 run_done     = 1'b0;

    t_elem_result exp_buf [EXP_DEPTH];
    int           exp_wr         = 0;
    int           exp_rd         = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           mismatch_count = 0;
    longint       cycle_count    = 0;

    lexicographic_permutation_generator #(
        .MAX_SET(MAX_SET)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_set_size (i_cfg_set_size),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_element      (o_element),
        .o_last_of_run  (o_last_of_run),
        .o_exhausted    (o_exhausted)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // permutation predictor
    function automatic logic [MAX_SET-1:0] value_bit(int unsigned v);
        logic [MAX_SET-1:0] b;
        b = '0;
        if (v >= 1 && v <= MAX_SET) b[v-1] = 1'b1;
        return b;
    endfunction

    function automatic int unsigned effective_size(t_size s);
        int unsigned n;
        n = s;
        if (n < 1) n = 1;
        if (n > MAX_SET) n = MAX_SET;
        return n;
    endfunction

    function automatic void fill_lowest(int unsigned from, int unsigned n);
        for (int unsigned pos = from; pos < n; pos++) begin
            for (int unsigned v = 1; v <= n; v++) begin
                if ((used_vals & value_bit(v)) == '0) begin
                    chosen[pos] = t_val'(v);
                    used_vals |= value_bit(v);
                    break;
                end
            end
        end
    endfunction

    function automatic bit next_in_order(int unsigned n);
        int unsigned lvl;
        int unsigned v;
        lvl = n;
        while (lvl > 0) begin
            lvl--;
            used_vals &= ~value_bit(chosen[lvl]);
            for (v = chosen[lvl] + 1; v <= n; v++) begin
                if ((used_vals & value_bit(v)) == '0) begin
                    chosen[lvl] = t_val'(v);
                    used_vals |= value_bit(v);
                    fill_lowest(lvl + 1, n);
                    return 1'b1;
                end
            end
            chosen[lvl] = '0;
        end
        return 1'b0;
    endfunction

    function automatic void exp_put(t_elem_result r);
        exp_buf[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic void predict_permutation(bit restart);
        int unsigned n;
        t_elem_result r;
        n = effective_size(size_reg);
        if (restart || !perm_started) begin
            for (int i = 0; i < MAX_SET; i++) chosen[i] = '0;
            used_vals = '0;
            fill_lowest(0, n);
            perm_started = 1'b1;
            run_done = 1'b0;
        end else if (!run_done) begin
            if (!next_in_order(n)) run_done = 1'b1;
        end
        if (run_done) begin
            r.element = '0;
            r.last_of_run = 1'b1;
            r.exhausted = 1'b1;
            exp_put(r);
        end else begin
            for (int unsigned k = 0; k < n; k++) begin
                r.element = chosen[k];
                r.last_of_run = (k == n - 1);
                r.exhausted = 1'b0;
                exp_put(r);
            end
        end
    endfunction

    always @(posedge i_clk) begin : check_permutation_output
        t_elem_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected item: element=%0d last=%0b exhausted=%0b",
                             o_element, o_last_of_run, o_exhausted);
            end else begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_element !== want.element || o_last_of_run !== want.last_of_run ||
                    o_exhausted !== want.exhausted) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: element exp %0d got %0d, last exp %0b got %0b,",
                                  " exhausted exp %0b got %0b"},
                                 want.element, o_element, want.last_of_run, o_last_of_run,
                                 want.exhausted, o_exhausted);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_request(bit restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (o_in_stall);
        predict_permutation(restart);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(t_size s);
        wait_drained();
        i_cfg_valid    <= 1'b1;
        i_cfg_set_size <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_reg     = s;
        perm_started = 1'b0;
        run_done     = 1'b0;
    endtask

    // default size, advance before any start acts as a restart
    task automatic test_default_size();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // runs that reach the end, repeated exhausted item, size zero acting as one
    task automatic test_exhaustion();
        write_size(t_size'(1));
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        write_size(t_size'(0));
        send_request(1'b0);
        send_request(1'b0);
        write_size(t_size'(2));
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // largest size and a size above the maximum
    task automatic test_size_extremes();
        write_size(t_size'(8));
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        write_size(t_size'(15));
        send_request(1'b0);
        send_request(1'b0);
    endtask

    // rewriting the size mid-run starts over at the identity
    task automatic test_write_mid_run();
        write_size(t_size'(3));
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        write_size(t_size'(3));
        send_request(1'b0);
    endtask

    task automatic test_random(int idle_pct, int stall_pct, int items);
        int sent;
        int seg_len;
        int unsigned fact;
        t_size sz;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) < 7) begin
                sz = t_size'($urandom_range(4));
                fact = 1;
                for (int unsigned i = 2; i <= effective_size(sz); i++) fact *= i;
                seg_len = fact + $urandom_range(1, 3);
            end else begin
                sz = t_size'($urandom_range(5, 15));
                seg_len = $urandom_range(3, 10);
            end
            write_size(sz);
            for (int i = 0; i < seg_len; i++) begin
                send_request($urandom_range(99) < 6);
                sent++;
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_size();
        test_exhaustion();
        test_size_extremes();
        test_write_mid_run();
        test_random(0, 0, 100);
        test_random(87, 0, 100);
        test_random(0, 87, 100);
        test_random(9, 9, 90);
        wait_drained();
        if (mismatch_count == 0 && exp_wr == exp_rd) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
